@@ sv/weighted_gram_matrix_accumulator_assert.svh @@
// Assertion macros for the Gram accumulator.
`ifndef WEIGHTED_GRAM_MATRIX_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_GRAM_MATRIX_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WGMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("wgma assertion failed");

// Next-cycle implication, checked out of reset.
`define WGMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("wgma assertion failed");

`endif

@@ sv/wgma_pkg.sv @@
`timescale 1ns / 1ps

package wgma_pkg;

  localparam int MAX_DIM = 128;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);

  localparam int VAL_W  = 16;
  localparam int WGT_W  = 16;
  localparam int SEL_W  = 7;
  localparam int CFG_W  = 8;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 2 * VAL_W;
  localparam int CT_W   = PROD_W + WGT_W + 1;
  localparam int TERM_W = CT_W - WGT_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(128);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  function automatic logic [ADDR_W-1:0] gram_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

endpackage

@@ sv/weighted_gram_matrix_accumulator.sv @@
`timescale 1ns / 1ps

// Accumulates an unweighted word Gram matrix and a row-weighted context Gram
// matrix (48-bit saturating, sticky overflow flag) in one 96-bit-wide memory.
// Per accepted command: a push that does not complete a row leaves busy low.
// The push that completes a row keeps busy high while the row is swept: the
// Gram memory does one read-modify-write per cycle while a row index is swept,
// and each row index first fetches its vector elements from the row buffer.
// A read keeps busy high for one cycle and its result strobe is registered from
// the read state. A clear, and likewise the pass after reset, zeroes the
// memory one entry per cycle: all 16384 entries, with busy high. The configuration
// port is always ready. The result strobe lasts one cycle; the receiver cannot
// stall it.
module weighted_gram_matrix_accumulator
  import wgma_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              op_i,
  input  logic signed [VAL_W-1:0] word_value_i,
  input  logic signed [VAL_W-1:0] ctx_value_i,
  input  logic [WGT_W-1:0]        row_weight_i,
  input  logic [SEL_W-1:0]        row_index_i,
  input  logic [SEL_W-1:0]        col_index_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_W-1:0]        cfg_data_i,
  output logic                    result_valid_o,
  output logic signed [ACC_W-1:0] word_gram_o,
  output logic signed [ACC_W-1:0] ctx_gram_o,
  output logic                    overflow_o
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_CLEAR   = 7'b0000010,
    ST_LOAD_I  = 7'b0000100,
    ST_LATCH_I = 7'b0001000,
    ST_SWEEP   = 7'b0010000,
    ST_DRAIN   = 7'b0100000,
    ST_READ    = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   cfg_dim_q;
  logic [IDX_W-1:0]   dim_m1_q, dim_m1_d, eff_dim_m1;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   i_q, i_d, j_q, j_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               sat_q, sat_d;
  logic               rd_ok_q, rd_ok_d;
  logic               s1_vld_q, s1_vld_d, s2_vld_q, s3_vld_q;
  logic               result_valid_q;

  logic [WGT_W-1:0]         weight_q;
  logic signed [VAL_W-1:0]  wi_q, ci_q;
  logic [ADDR_W-1:0]        a1_q, a2_q, a3_q;
  logic signed [PROD_W-1:0] wp2_q, cp2_q, wp3_q, wp4_q;
  logic signed [TERM_W-1:0] ct3_q, ct4_q;
  logic signed [ACC_W-1:0]  word_out_q, ctx_out_q;

  logic                     accept, row_done, latch_i;
  logic                     buf_we;
  logic [IDX_W-1:0]         buf_raddr;
  logic [2*VAL_W-1:0]       buf_rdata;
  logic signed [VAL_W-1:0]  wj, cj;
  logic signed [PROD_W-1:0] wp1, cp1;
  logic signed [CT_W-1:0]   ct_full;

  logic                     gram_we;
  logic [ADDR_W-1:0]        gram_waddr, gram_raddr;
  logic [2*ACC_W-1:0]       gram_wdata, gram_rdata;
  logic signed [ACC_W-1:0]  old_w, old_c, new_w, new_c;
  logic signed [ACC_W:0]    sum_w, sum_c;
  logic                     sat_w, sat_c;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_dim_q == '0) begin
      eff_dim_m1 = '0;
    end else if (int'(cfg_dim_q) > MAX_DIM) begin
      eff_dim_m1 = IDX_W'(MAX_DIM - 1);
    end else begin
      eff_dim_m1 = IDX_W'(cfg_dim_q - 1'b1);
    end
  end

  assign row_done = accept && (op_e'(op_i) == OP_PUSH) && (cnt_q >= eff_dim_m1);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    clr_d     = clr_q;
    dim_m1_d  = dim_m1_q;
    sat_d     = sat_q;
    rd_ok_d   = rd_ok_q;
    s1_vld_d  = 1'b0;
    buf_we    = 1'b0;
    buf_raddr = j_q;
    latch_i   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (op_e'(op_i))
            OP_PUSH: begin
              buf_we = 1'b1;
              if (row_done) begin
                cnt_d    = '0;
                dim_m1_d = eff_dim_m1;
                i_d      = '0;
                j_d      = '0;
                state_d  = ST_LOAD_I;
              end else begin
                cnt_d = IDX_W'(cnt_q + 1'b1);
              end
            end
            OP_READ: begin
              rd_ok_d = (int'(row_index_i) < MAX_DIM) && (int'(col_index_i) < MAX_DIM);
              state_d = ST_READ;
            end
            OP_CLEAR: begin
              cnt_d   = '0;
              sat_d   = 1'b0;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_d = ADDR_W'(clr_q + 1'b1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD_I: begin
        buf_raddr = i_q;
        state_d   = ST_LATCH_I;
      end
      ST_LATCH_I: begin
        latch_i = 1'b1;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        s1_vld_d = 1'b1;
        if (j_q == dim_m1_q) begin
          j_d = '0;
          if (i_q == dim_m1_q) begin
            state_d = ST_DRAIN;
          end else begin
            i_d     = IDX_W'(i_q + 1'b1);
            state_d = ST_LOAD_I;
          end
        end else begin
          j_d = IDX_W'(j_q + 1'b1);
        end
        // fetch the element of the next column
        buf_raddr = j_d;
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q && !s3_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (s3_vld_q && (sat_w || sat_c)) begin
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      cfg_dim_q      <= DIM_RESET;
      dim_m1_q       <= '0;
      cnt_q          <= '0;
      i_q            <= '0;
      j_q            <= '0;
      clr_q          <= '0;
      sat_q          <= 1'b0;
      rd_ok_q        <= 1'b0;
      s1_vld_q       <= 1'b0;
      s2_vld_q       <= 1'b0;
      s3_vld_q       <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      dim_m1_q       <= dim_m1_d;
      cnt_q          <= cnt_d;
      i_q            <= i_d;
      j_q            <= j_d;
      clr_q          <= clr_d;
      sat_q          <= sat_d;
      rd_ok_q        <= rd_ok_d;
      s1_vld_q       <= s1_vld_d;
      s2_vld_q       <= s1_vld_q;
      s3_vld_q       <= s2_vld_q;
      result_valid_q <= (state_q == ST_READ);
      if (cfg_valid_i) begin
        cfg_dim_q <= cfg_data_i;
      end
    end
  end

  // Row buffer: word element in the upper half, context element in the lower.
  wgma_ram #(
    .Width (2 * VAL_W),
    .Depth (MAX_DIM)
  ) u_row_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (cnt_q),
    .wdata_i ({word_value_i, ctx_value_i}),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  assign wj  = buf_rdata[2*VAL_W-1:VAL_W];
  assign cj  = buf_rdata[VAL_W-1:0];
  assign wp1 = wi_q * wj;
  assign cp1 = ci_q * cj;

  // Weighted context product; an arithmetic shift by 16 floors it.
  assign ct_full = cp2_q * $signed({1'b0, weight_q});

  always_ff @(posedge clk_i) begin
    if (row_done) begin
      weight_q <= row_weight_i;
    end
    if (latch_i) begin
      wi_q <= wj;
      ci_q <= cj;
    end
    a1_q  <= gram_addr(i_q, j_q);
    a2_q  <= a1_q;
    a3_q  <= a2_q;
    wp2_q <= wp1;
    cp2_q <= cp1;
    wp3_q <= wp2_q;
    wp4_q <= wp3_q;
    ct3_q <= ct_full[CT_W-1:WGT_W];
    ct4_q <= ct3_q;
    if (state_q == ST_READ) begin
      word_out_q <= rd_ok_q ? gram_rdata[2*ACC_W-1:ACC_W] : '0;
      ctx_out_q  <= rd_ok_q ? gram_rdata[ACC_W-1:0] : '0;
    end
  end

  // Read-modify-write stage: saturate each sum to the accumulator range.
  assign old_w = gram_rdata[2*ACC_W-1:ACC_W];
  assign old_c = gram_rdata[ACC_W-1:0];
  assign sum_w = $signed({old_w[ACC_W-1], old_w})
               + $signed({{(ACC_W+1-PROD_W){wp4_q[PROD_W-1]}}, wp4_q});
  assign sum_c = $signed({old_c[ACC_W-1], old_c})
               + $signed({{(ACC_W+1-TERM_W){ct4_q[TERM_W-1]}}, ct4_q});
  assign sat_w = sum_w[ACC_W] != sum_w[ACC_W-1];
  assign sat_c = sum_c[ACC_W] != sum_c[ACC_W-1];
  assign new_w = sat_w ? (sum_w[ACC_W] ? ACC_MIN : ACC_MAX) : sum_w[ACC_W-1:0];
  assign new_c = sat_c ? (sum_c[ACC_W] ? ACC_MIN : ACC_MAX) : sum_c[ACC_W-1:0];

  assign gram_we    = (state_q == ST_CLEAR) || s3_vld_q;
  assign gram_waddr = (state_q == ST_CLEAR) ? clr_q : a3_q;
  assign gram_wdata = (state_q == ST_CLEAR) ? '0 : {new_w, new_c};
  assign gram_raddr = (state_q == ST_IDLE)
                    ? gram_addr(IDX_W'(row_index_i), IDX_W'(col_index_i)) : a2_q;

  wgma_ram #(
    .Width (2 * ACC_W),
    .Depth (DEPTH)
  ) u_gram (
    .clk_i   (clk_i),
    .we_i    (gram_we),
    .waddr_i (gram_waddr),
    .wdata_i (gram_wdata),
    .raddr_i (gram_raddr),
    .rdata_o (gram_rdata)
  );

  assign result_valid_o = result_valid_q;
  assign word_gram_o    = word_out_q;
  assign ctx_gram_o     = ctx_out_q;
  assign overflow_o     = sat_q;

`include "weighted_gram_matrix_accumulator_assert.svh"

  `WGMA_ASSERT_NEXT(a_read_strobe, clk_i, rst_ni, state_q == ST_READ, result_valid_o)
  `WGMA_ASSERT_NOW(a_pipe_in_row, clk_i, rst_ni, s1_vld_q || s2_vld_q || s3_vld_q, state_q != ST_IDLE && state_q != ST_CLEAR && state_q != ST_READ)
  `WGMA_ASSERT_NEXT(a_clear_flag, clk_i, rst_ni, accept && op_i == OP_CLEAR, !overflow_o && state_q == ST_CLEAR)

endmodule

@@ sv/wgma_ram.sv @@
`timescale 1ns / 1ps

module wgma_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import wgma_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint ACC_HI = ACC_MAX;
  localparam longint ACC_LO = ACC_MIN;
  localparam int NUM_PHASES = 14;
  localparam logic [CFG_W-1:0] PHASE_DIMS [NUM_PHASES] = '{
    8'd3, 8'd1, 8'd128, 8'd7, 8'd2, 8'd16, 8'd0,
    8'd5, 8'd255, 8'd11, 8'd4, 8'd200, 8'd9, 8'd6
  };

  typedef struct {
    logic signed [ACC_W-1:0] word;
    logic signed [ACC_W-1:0] ctx;
    logic                    ovf;
  } gram_read_t;

  function automatic int unsigned effective_dim(input logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  class gram_scoreboard;
    longint                  word_acc[DEPTH];
    longint                  ctx_acc[DEPTH];
    logic signed [VAL_W-1:0] word_row[MAX_DIM];
    logic signed [VAL_W-1:0] ctx_row[MAX_DIM];
    int unsigned             fill;
    logic [CFG_W-1:0]        dim_reg;
    bit                      sticky_sat;
    gram_read_t              pending_reads[$];
    int unsigned             errors;

    function new();
      dim_reg = DIM_RESET;
      errors  = 0;
      clear_stores();
    endfunction

    function void clear_stores();
      for (int a = 0; a < DEPTH; a++) begin
        word_acc[a] = 0;
        ctx_acc[a]  = 0;
      end
      fill       = 0;
      sticky_sat = 1'b0;
    endfunction

    function longint sat_accumulate(input longint acc, input longint term);
      longint s;
      s = acc + term;
      if (s > ACC_HI) begin
        sticky_sat = 1'b1;
        return ACC_HI;
      end
      if (s < ACC_LO) begin
        sticky_sat = 1'b1;
        return ACC_LO;
      end
      return s;
    endfunction

    function void accumulate_outer_products(input int unsigned d, input logic [WGT_W-1:0] wt);
      int unsigned a;
      longint wp, cp, ct;
      for (int i = 0; i < d; i++) begin
        for (int j = 0; j < d; j++) begin
          a  = i * MAX_DIM + j;
          wp = longint'(word_row[i]) * longint'(word_row[j]);
          cp = longint'(ctx_row[i]) * longint'(ctx_row[j]);
          // arithmetic shift of a signed value floors
          ct = (cp * longint'(wt)) >>> WGT_W;
          word_acc[a] = sat_accumulate(word_acc[a], wp);
          ctx_acc[a]  = sat_accumulate(ctx_acc[a], ct);
        end
      end
    endfunction

    function void note_command(input logic [1:0] op,
                               input logic signed [VAL_W-1:0] w, c,
                               input logic [WGT_W-1:0] wt,
                               input logic [SEL_W-1:0] r, col);
      int unsigned d, pos;
      gram_read_t e;
      case (op)
        OP_PUSH: begin
          d   = effective_dim(dim_reg);
          pos = (fill >= MAX_DIM) ? MAX_DIM - 1 : fill;
          word_row[pos] = w;
          ctx_row[pos]  = c;
          if (fill + 1 >= d) begin
            accumulate_outer_products(d, wt);
            fill = 0;
          end else begin
            fill++;
          end
        end
        OP_READ: begin
          e.word = '0;
          e.ctx  = '0;
          if (int'(r) < MAX_DIM && int'(col) < MAX_DIM) begin
            e.word = ACC_W'(word_acc[int'(r) * MAX_DIM + int'(col)]);
            e.ctx  = ACC_W'(ctx_acc[int'(r) * MAX_DIM + int'(col)]);
          end
          e.ovf = sticky_sat;
          pending_reads = {pending_reads, e};
        end
        OP_CLEAR: clear_stores();
        default: ;
      endcase
    endfunction

    function void check_read(input logic signed [ACC_W-1:0] word, ctx, input logic ovf);
      gram_read_t e;
      if (pending_reads.size() == 0) begin
        $error("result strobe with no read outstanding");
        errors++;
        return;
      end
      e = pending_reads.pop_front();
      if (word !== e.word) begin
        $error("word_gram: expected %0d, got %0d", e.word, word);
        errors++;
      end
      if (ctx !== e.ctx) begin
        $error("ctx_gram: expected %0d, got %0d", e.ctx, ctx);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("overflow: expected %0b, got %0b", e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [1:0]              op_i;
  logic signed [VAL_W-1:0] word_value_i;
  logic signed [VAL_W-1:0] ctx_value_i;
  logic [WGT_W-1:0]        row_weight_i;
  logic [SEL_W-1:0]        row_index_i;
  logic [SEL_W-1:0]        col_index_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    result_valid_o;
  logic signed [ACC_W-1:0] word_gram_o;
  logic signed [ACC_W-1:0] ctx_gram_o;
  logic                    overflow_o;

  int idle_limit;
  gram_scoreboard gram_sb = new();

  weighted_gram_matrix_accumulator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .word_value_i   (word_value_i),
    .ctx_value_i    (ctx_value_i),
    .row_weight_i   (row_weight_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .word_gram_o    (word_gram_o),
    .ctx_gram_o     (ctx_gram_o),
    .overflow_o     (overflow_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (result_valid_o === 1'b1) begin
      gram_sb.check_read(word_gram_o, ctx_gram_o, overflow_o);
    end
  end

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] random_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 16'h0001;
      default: return WGT_W'($urandom);
    endcase
  endfunction

  task automatic send(input logic [1:0] op,
                      input logic signed [VAL_W-1:0] w, c,
                      input logic [WGT_W-1:0] wt,
                      input logic [SEL_W-1:0] r, col);
    int gap;
    gap = $urandom_range(0, idle_limit);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    op_i         <= op;
    word_value_i <= w;
    ctx_value_i  <= c;
    row_weight_i <= wt;
    row_index_i  <= r;
    col_index_i  <= col;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    gram_sb.note_command(op, w, c, wt, r, col);
  endtask

  task automatic push_elem(input logic signed [VAL_W-1:0] w, c, input logic [WGT_W-1:0] wt);
    send(OP_PUSH, w, c, wt, SEL_W'($urandom), SEL_W'($urandom));
  endtask

  task automatic read_entry(input logic [SEL_W-1:0] r, col);
    send(OP_READ, random_value(), random_value(), random_weight(), r, col);
  endtask

  task automatic random_item(input int unsigned eff, input int unsigned push_cut);
    int unsigned pick;
    pick = $urandom_range(0, 199);
    if (pick < 1) begin
      send(OP_CLEAR, random_value(), random_value(), random_weight(),
           SEL_W'($urandom), SEL_W'($urandom));
    end else if (pick < 5) begin
      send(OP_UNUSED, random_value(), random_value(), random_weight(),
           SEL_W'($urandom), SEL_W'($urandom));
    end else if (pick < push_cut) begin
      push_elem(random_value(), random_value(), random_weight());
    end else if ($urandom_range(0, 9) < 7) begin
      // mostly hit the part of the matrix that the current dimension fills
      read_entry(SEL_W'($urandom_range(0, eff - 1)), SEL_W'($urandom_range(0, eff - 1)));
    end else begin
      read_entry(SEL_W'($urandom), SEL_W'($urandom));
    end
  endtask

  // Hold off until reads are answered and any row update or clear has finished.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (gram_sb.pending_reads.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_dim(input logic [CFG_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    gram_sb.dim_reg = d;
  endtask

  initial begin
    int unsigned eff;
    int unsigned items;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    op_i         <= OP_PUSH;
    word_value_i <= '0;
    ctx_value_i  <= '0;
    row_weight_i <= '0;
    row_index_i  <= '0;
    col_index_i  <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    idle_limit = 8;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    read_entry(7'd0, 7'd0);
    read_entry(7'd127, 7'd127);
    send(OP_UNUSED, random_value(), random_value(), random_weight(), 7'd127, 7'd0);
    push_elem(16'sh8000, 16'sh7FFF, 16'hFFFF);
    push_elem(16'sh7FFF, 16'sh8000, 16'h0000);
    push_elem(16'sh0000, 16'shFFFF, 16'h1234);
    // shrink the dimension mid-row: the next push closes the row on entries 0 and 1
    settle();
    write_dim(8'd2);
    push_elem(16'shFFFF, 16'sh0000, 16'hFFFF);
    read_entry(7'd0, 7'd0);
    read_entry(7'd0, 7'd1);
    read_entry(7'd1, 7'd0);
    read_entry(7'd1, 7'd1);
    read_entry(7'd2, 7'd2);
    push_elem(16'sh7FFF, 16'sh7FFF, 16'h8000);
    // drop the half-filled row
    send(OP_CLEAR, random_value(), random_value(), random_weight(), 7'd0, 7'd0);
    read_entry(7'd0, 7'd1);
    settle();
    write_dim(8'd0);
    push_elem(16'sh8000, 16'sh8000, 16'h0000);
    push_elem(16'sh7FFF, 16'sh8000, 16'h0001);
    read_entry(7'd0, 7'd0);
    read_entry(7'd1, 7'd1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_dim(PHASE_DIMS[p]);
      eff = effective_dim(PHASE_DIMS[p]);
      idle_limit = ($urandom_range(0, 3) == 0) ? 0 : 8;
      items = (eff == MAX_DIM) ? 165 : 115;
      repeat (items) random_item(eff, (eff == MAX_DIM) ? 170 : 120);
    end

    // end on a clear and reads of the zeroed stores
    settle();
    write_dim(8'd1);
    idle_limit = 8;
    send(OP_CLEAR, random_value(), random_value(), random_weight(), 7'd0, 7'd0);
    read_entry(7'd0, 7'd0);
    read_entry(7'd0, 7'd1);

    start <= 1'b0;
    for (int w = 0; w < 64 && gram_sb.pending_reads.size() != 0; w++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (gram_sb.pending_reads.size() != 0) begin
      $error("%0d reads never answered", gram_sb.pending_reads.size());
      gram_sb.errors++;
    end
    if (gram_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
